// ----- hw/rtl/ipv6_lpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 LPM package
// Shared types and codes for the route cell chain.
// ----------------------------------------------------------------------------
package ipv6_lpm_pkg;

    localparam logic [1:0] ACT_FORWARD = 2'd0;
    localparam logic [1:0] ACT_ADD     = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [0:0] REG_LOCAL_HI = 1'b0;
    localparam logic [0:0] REG_LOCAL_LO = 1'b1;

    localparam logic [2:0] VERD_LOCAL   = 3'd0;
    localparam logic [2:0] VERD_SEND    = 3'd1;
    localparam logic [2:0] VERD_NOROUTE = 3'd2;
    localparam logic [2:0] VERD_HOPLIM  = 3'd3;
    localparam logic [2:0] VERD_ADDED   = 3'd4;
    localparam logic [2:0] VERD_DUP     = 3'd5;
    localparam logic [2:0] VERD_FULL    = 3'd6;
    localparam logic [2:0] VERD_CLEARED = 3'd7;

    localparam logic [7:0] MAX_LEN = 8'd128;

    typedef struct packed {
        logic [127:0] prefix;
        logic [7:0]   len;
        logic [127:0] gateway;
    } route_t;

    // status a cell reports for the current word
    typedef struct packed {
        logic match;
        logic dup;
        logic longer;
    } cell_stat_t;

    function automatic logic [127:0] len_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++)
            m[127 - b] = (b < len);
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ipv6_lpm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 LPM route cell
// Holds one route, compares it with the word in flight and shifts it to the
// next cell when a new route is inserted ahead of it.
// ----------------------------------------------------------------------------
module ipv6_lpm_cell (
    input  wire                   clk,
    input  wire                   shift_en,
    input  wire                   load_en,
    input  ipv6_lpm_pkg::route_t  new_route,
    input  ipv6_lpm_pkg::route_t  prev_route,
    input  wire  [127:0]          addr,
    output ipv6_lpm_pkg::route_t  route,
    output ipv6_lpm_pkg::cell_stat_t stat
);
    import ipv6_lpm_pkg::*;

    route_t route_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
            route_reg <= new_route;
        else if (shift_en)
            route_reg <= prev_route;
    end

    assign route = route_reg;

    always_comb
    begin
        stat.match  = (((route_reg.prefix ^ addr) & len_mask(route_reg.len)) == '0);
        stat.dup    = (route_reg == new_route);
        stat.longer = (route_reg.len > new_route.len);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ipv6_lpm_forwarding_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 longest prefix match forwarding table
// Sorted chain of route cells, longest prefix first; clear, add, forward.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready
//  out     | output    | out_valid / out_ready
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// Every cell compares against the word combinationally, so one word is taken
// per cycle unless stalled; the result sits in an output register and the
// next word is taken in the same cycle the result leaves. Stall on out_ready
// holds the register. Reset empties the table; route storage is not cleared.
// ----------------------------------------------------------------------------
module ipv6_lpm_forwarding_table_core #(
    parameter int ROUTE_ENTRIES = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [63:0]  cfg_data,
    input  wire          in_valid,
    output logic         in_ready,
    input  wire  [1:0]   action,
    input  wire  [63:0]  addr_hi,
    input  wire  [63:0]  addr_lo,
    input  wire  [7:0]   prefix_length,
    input  wire  [63:0]  gateway_hi,
    input  wire  [63:0]  gateway_lo,
    input  wire  [7:0]   hop_limit,
    output logic         out_valid,
    input  wire          out_ready,
    output logic [2:0]   verdict,
    output logic [63:0]  next_hop_hi,
    output logic [63:0]  next_hop_lo,
    output logic [7:0]   new_hop_limit
);
    import ipv6_lpm_pkg::*;

    localparam int CW = $clog2(ROUTE_ENTRIES + 1);

    logic [63:0]   local_hi_reg, local_lo_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          valid_reg;
    logic [2:0]    verd_reg;
    logic [127:0]  nh_reg;
    logic [7:0]    hop_reg;

    route_t        new_route;
    route_t        routes [ROUTE_ENTRIES];
    cell_stat_t    stats  [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] live, ins_at, shift_v, load_v;
    logic [127:0]  addr, local_addr;
    logic          do_add, accept;
    logic [2:0]    verd_next;
    logic [127:0]  nh_next;
    logic [7:0]    hop_next;
    logic          any_dup, full;

    assign addr       = {addr_hi, addr_lo};
    assign local_addr = {local_hi_reg, local_lo_reg};
    assign new_route.prefix  = addr;
    assign new_route.len     = (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;
    assign new_route.gateway = {gateway_hi, gateway_lo};

    genvar g;
    generate
        for (g = 0; g < ROUTE_ENTRIES; g++)
        begin : g_cell
            ipv6_lpm_cell u_cell (
                .clk        (clk),
                .shift_en   (shift_v[g]),
                .load_en    (load_v[g]),
                .new_route  (new_route),
                .prev_route (routes[(g == 0) ? 0 : g - 1]),
                .addr       (addr),
                .route      (routes[g]),
                .stat       (stats[g])
            );
            assign live[g] = (CW'(g) < count_reg);
            // insert where the first cell holds no longer prefix
            assign ins_at[g] = live[g] ? !stats[g].longer : 1'b1;
            if (g == 0)
            begin : g_first
                assign shift_v[g] = 1'b0;
                assign load_v[g]  = do_add && ins_at[g];
            end
            else
            begin : g_rest
                assign shift_v[g] = do_add && ins_at[g - 1] && live[g - 1];
                assign load_v[g]  = do_add && ins_at[g] && !ins_at[g - 1];
            end
        end
    endgenerate

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= CW'(ROUTE_ENTRIES));

    always_comb
    begin
        any_dup = 1'b0;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
            any_dup = any_dup | (live[i] && stats[i].dup);
    end

    assign do_add = accept && (action == ACT_ADD) && !any_dup && !full;

    always_comb
    begin
        logic   found;
        route_t hit;
        found      = 1'b0;
        hit        = routes[0];
        for (int i = ROUTE_ENTRIES - 1; i >= 0; i--)
        begin
            if (live[i] && stats[i].match)
            begin
                found = 1'b1;
                hit   = routes[i];
            end
        end
        verd_next  = VERD_NOROUTE;
        nh_next    = '0;
        hop_next   = hop_limit;
        count_next = count_reg;
        case (action)
            ACT_CLEAR:
            begin
                verd_next  = VERD_CLEARED;
                count_next = '0;
            end
            ACT_ADD:
            begin
                if (any_dup)
                    verd_next = VERD_DUP;
                else if (full)
                    verd_next = VERD_FULL;
                else
                begin
                    verd_next  = VERD_ADDED;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_FORWARD:
            begin
                if (addr == local_addr)
                    verd_next = VERD_LOCAL;
                else if (!found)
                    verd_next = VERD_NOROUTE;
                else if (hop_limit <= 8'd1)
                    verd_next = VERD_HOPLIM;
                else
                begin
                    verd_next = VERD_SEND;
                    hop_next  = hop_limit - 8'd1;
                    nh_next   = (((addr ^ local_addr) & len_mask(hit.len)) == '0)
                                ? addr : hit.gateway;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_hi_reg <= '0;
            local_lo_reg <= '0;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_LOCAL_HI)
                local_hi_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_LOCAL_LO)
                local_lo_reg <= cfg_data;
            if (accept && action != ACT_UNUSED)
                count_reg <= count_next;
            if (accept)
                valid_reg <= (action != ACT_UNUSED);
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            verd_reg <= verd_next;
            nh_reg   <= nh_next;
            hop_reg  <= hop_next;
        end
    end

    assign out_valid     = valid_reg;
    assign verdict       = verd_reg;
    assign next_hop_hi   = nh_reg[127:64];
    assign next_hop_lo   = nh_reg[63:0];
    assign new_hop_limit = hop_reg;

endmodule
`default_nettype wire
